@@ hdl/ppr_pkg.sv @@
// ----------------------------------------------------------------------------
// ppr_pkg
// Types and fixed constants for the palette pixel replicator: the request and
// response words, the job record that goes from the front to the back, and
// the opcodes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

   // fixed field widths
   localparam int COL_W    = 9;    // source column counter
   localparam int ROW_W    = 8;    // source row counter
   localparam int FAC_W    = 4;    // factor registers
   localparam int CNT_W    = 3;    // copy counters, 0..7
   localparam int PITCH_W  = 13;   // 512 * 8 fits
   localparam int LINE_W   = 11;   // row * vert factor, up to 2040
   localparam int CBASE_W  = 12;   // column * horiz factor, up to 4088
   localparam int ADDR_W   = 22;
   localparam int COLOR_W  = 24;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // job queue
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = 2;
   localparam int QCNT_W   = 3;

   // opcodes
   localparam logic OP_PIXEL     = 1'b0;
   localparam logic OP_PAL_WRITE = 1'b1;

   // register indexes (address bit 2)
   localparam logic REG_HORIZ = 1'b0;
   localparam logic REG_VERT  = 1'b1;

   localparam logic [FAC_W-1:0] FACTOR_RESET = 4'd2;
   localparam logic [FAC_W-1:0] MAX_FACTOR   = 4'd8;

   typedef struct packed {
      logic       operation;
      logic [7:0] color_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } ppr_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  dest_address;
      logic [COLOR_W-1:0] pixel_color;
      logic               last_of_block;
   } ppr_rsp_type;

   // one source pixel ready for replication
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [ADDR_W-1:0]  line_addr;
      logic [CBASE_W-1:0] col_base;
      logic [PITCH_W-1:0] pitch;
      logic [FAC_W-1:0]   hf;
      logic [FAC_W-1:0]   vf;
   } ppr_job_type;

   // zero acts as one, anything above eight as eight
   function automatic logic [FAC_W-1:0] clamp_factor(input logic [FAC_W-1:0] f);
      logic [FAC_W-1:0] r;
      r = f;
      if (f == '0) begin
         r = 4'd1;
      end else if (f > MAX_FACTOR) begin
         r = MAX_FACTOR;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/ppr_ram.sv @@
// ----------------------------------------------------------------------------
// ppr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/ppr_front.sv @@
// ----------------------------------------------------------------------------
// ppr_front
// Accepts request words, writes the palette or looks a pixel up, tracks the
// raster position and builds one job per pixel for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_front
   import ppr_pkg::*;
#(
   parameter int SRC_WIDTH     = 320,
   parameter int SRC_HEIGHT    = 200,
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire ppr_req_type       req_word,
   input  wire logic [FAC_W-1:0]  horiz_factor,
   input  wire logic [FAC_W-1:0]  vert_factor,
   input  wire logic [QCNT_W-1:0] q_count,
   output      logic              q_push,
   output      ppr_job_type       q_job
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam logic [COL_W:0] SRC_W_V   = SRC_WIDTH[COL_W:0];
   localparam logic [ROW_W:0] SRC_H_V   = SRC_HEIGHT[ROW_W:0];
   localparam logic [8:0]     PAL_D_V   = PALETTE_DEPTH[8:0];
   localparam logic [QCNT_W:0] QDEPTH_V = QDEPTH[QCNT_W:0];

   logic               accept;
   logic               is_pixel;
   logic               in_range;
   logic [FAC_W-1:0]   hf;
   logic [FAC_W-1:0]   vf;
   logic [PITCH_W-1:0] pitch;
   logic [LINE_W-1:0]  row_line;
   logic [CBASE_W-1:0] col_base;
   logic [COLOR_W-1:0] rd_color;
   logic [LINE_W+PITCH_W-1:0] line_prod;

   logic [COL_W-1:0]   col_ff,  col_in;
   logic [ROW_W-1:0]   row_ff,  row_in;
   logic               s1_valid_ff;
   logic               s1_zero_ff;
   logic [LINE_W-1:0]  s1_line_ff;
   logic [CBASE_W-1:0] s1_col_ff;
   logic [PITCH_W-1:0] s1_pitch_ff;
   logic [FAC_W-1:0]   s1_hf_ff;
   logic [FAC_W-1:0]   s1_vf_ff;

   // hold off while the queue could not take the word in flight plus one
   assign req_stall = ({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_ff}) >= QDEPTH_V;
   assign accept    = req_valid && !req_stall;
   assign is_pixel  = (req_word.operation == OP_PIXEL);
   assign in_range  = {1'b0, req_word.color_index} < PAL_D_V;

   // palette store
   ppr_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (accept && !is_pixel && in_range),
      .wr_addr (req_word.color_index[PAL_AW-1:0]),
      .wr_data ({req_word.red, req_word.green, req_word.blue}),
      .rd_en   (accept && is_pixel),
      .rd_addr (req_word.color_index[PAL_AW-1:0]),
      .rd_data (rd_color)
   );

   // scaling terms for this pixel
   assign hf       = clamp_factor(horiz_factor);
   assign vf       = clamp_factor(vert_factor);
   assign pitch    = {{(PITCH_W-COL_W-1){1'b0}}, SRC_W_V} * {{(PITCH_W-FAC_W){1'b0}}, hf};
   assign row_line = {{(LINE_W-ROW_W){1'b0}}, row_ff} * {{(LINE_W-FAC_W){1'b0}}, vf};
   assign col_base = {{(CBASE_W-COL_W){1'b0}}, col_ff} * {{(CBASE_W-FAC_W){1'b0}}, hf};

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept && is_pixel) begin
         if (({1'b0, col_ff} + 1'b1) >= SRC_W_V) begin
            col_in = '0;
            if (({1'b0, row_ff} + 1'b1) >= SRC_H_V) begin
               row_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept && is_pixel;
      end
   end

   // stage one: waits for the palette read
   always_ff @(posedge clock) begin
      if (accept && is_pixel) begin
         s1_zero_ff  <= !in_range;
         s1_line_ff  <= row_line;
         s1_col_ff   <= col_base;
         s1_pitch_ff <= pitch;
         s1_hf_ff    <= hf;
         s1_vf_ff    <= vf;
      end
   end

   // first line address, then into the queue
   assign line_prod = {{PITCH_W{1'b0}}, s1_line_ff} * {{LINE_W{1'b0}}, s1_pitch_ff};

   assign q_push         = s1_valid_ff;
   assign q_job.color    = s1_zero_ff ? '0 : rd_color;
   assign q_job.line_addr = line_prod[ADDR_W-1:0];
   assign q_job.col_base = s1_col_ff;
   assign q_job.pitch    = s1_pitch_ff;
   assign q_job.hf       = s1_hf_ff;
   assign q_job.vf       = s1_vf_ff;

endmodule

`default_nettype wire

@@ hdl/ppr_queue.sv @@
// ----------------------------------------------------------------------------
// ppr_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_queue
   import ppr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ppr_job_type       push_job,
   input  wire logic              pop,
   output      logic              head_valid,
   output      ppr_job_type       head_job,
   output      logic [QCNT_W-1:0] count
);

   ppr_job_type       entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   // entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < QCNT_W'(QDEPTH))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

@@ hdl/ppr_back.sv @@
// ----------------------------------------------------------------------------
// ppr_back
// Replicates one queued pixel into hf x vf response words, one word per
// cycle while the response is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_back
   import ppr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire ppr_job_type q_job,
   output      logic        q_pop,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      ppr_rsp_type rsp_word
);

   ppr_job_type       job_ff;
   logic              busy_ff;
   logic [ADDR_W-1:0] line_ff;
   logic [CNT_W-1:0]  i_ff;
   logic [CNT_W-1:0]  j_ff;
   logic              rsp_valid_ff;
   ppr_rsp_type       rsp_word_ff;

   logic              go;
   logic              row_end;
   logic              last_copy;
   logic [ADDR_W-1:0] addr;

   assign row_end   = ({1'b0, i_ff} == (job_ff.hf - 1'b1));
   assign last_copy = row_end && ({1'b0, j_ff} == (job_ff.vf - 1'b1));
   assign go        = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = q_valid && (!busy_ff || (go && last_copy));
   assign addr      = line_ff + {{(ADDR_W-CBASE_W){1'b0}}, job_ff.col_base}
                    + {{(ADDR_W-CNT_W){1'b0}}, i_ff};

   // copy sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (q_pop) begin
         busy_ff <= 1'b1;
      end else if (go && last_copy) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff  <= q_job;
         line_ff <= q_job.line_addr;
         i_ff    <= '0;
         j_ff    <= '0;
      end else if (go) begin
         if (row_end) begin
            i_ff    <= '0;
            j_ff    <= j_ff + 1'b1;
            line_ff <= line_ff + {{(ADDR_W-PITCH_W){1'b0}}, job_ff.pitch};
         end else begin
            i_ff <= i_ff + 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_word_ff.dest_address  <= addr;
         rsp_word_ff.pixel_color   <= job_ff.color;
         rsp_word_ff.last_of_block <= last_copy;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   a_copy_bounds: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, i_ff} < job_ff.hf) && ({1'b0, j_ff} < job_ff.vf))
      else $error("copy counter out of block");

   a_last_flagged: assert property (@(posedge clock) disable iff (reset)
      go && last_copy |=> rsp_valid_ff && rsp_word_ff.last_of_block)
      else $error("final copy not flagged");
`endif

endmodule

`default_nettype wire

@@ hdl/palette_pixel_replicator.sv @@
// ----------------------------------------------------------------------------
// palette_pixel_replicator
// Palette lookup of 8-bit indexed pixels followed by integer pixel
// replication into a scaled frame buffer address space.
// ----------------------------------------------------------------------------
//
//   channel   direction  ports                          word
//   request   in         req_valid / req_stall          ppr_req_type
//   response  out        rsp_valid / rsp_stall          ppr_rsp_type
//   config    in         psel penable pwrite paddr ...  32-bit register
//
// A request word is taken every cycle while the job queue has room; a
// palette write finishes at acceptance and produces no response.
// A pixel enters the queue in the cycle after acceptance, then passes the copy
// sequencer and the output register before its first response word is valid;
// the sequencer emits hf*vf words (4 at the 2x2 default), one per unstalled cycle.
// It takes the next queued pixel as the last word of the current one goes out.
// Reset clears the raster position and loads both factors with 2; palette
// entries are undefined until written, and no clearing pass runs.
// A stalled response holds in the output register; the queue lets requests
// keep flowing until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_pixel_replicator
   import ppr_pkg::*;
#(
   parameter int SRC_WIDTH     = 320,
   parameter int SRC_HEIGHT    = 200,
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire ppr_req_type       req_word,
   // response channel
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      ppr_rsp_type       rsp_word,
   // register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output      logic [CSR_DW-1:0] prdata,
   output      logic              pready
);

   logic [FAC_W-1:0]  horiz_ff;
   logic [FAC_W-1:0]  vert_ff;
   logic              csr_wr;
   logic              q_push;
   logic              q_pop;
   logic              q_valid;
   logic [QCNT_W-1:0] q_count;
   ppr_job_type       push_job;
   ppr_job_type       head_job;

   // factor registers
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         horiz_ff <= FACTOR_RESET;
         vert_ff  <= FACTOR_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_VERT) begin
            vert_ff <= pwdata[FAC_W-1:0];
         end else begin
            horiz_ff <= pwdata[FAC_W-1:0];
         end
      end
   end

   assign prdata = {{(CSR_DW-FAC_W){1'b0}}, (paddr[2] == REG_HORIZ) ? horiz_ff : vert_ff};

   ppr_front #(
      .SRC_WIDTH     (SRC_WIDTH),
      .SRC_HEIGHT    (SRC_HEIGHT),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .horiz_factor (horiz_ff),
      .vert_factor  (vert_ff),
      .q_count      (q_count),
      .q_push       (q_push),
      .q_job        (push_job)
   );

   ppr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job),
      .count      (q_count)
   );

   ppr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
